// File: rtl/core/ghbp_pkg.sv
// ----------------------------------------------------------------------------
// ghbp_pkg
// Shared types, counter codes and the 2-bit counter update of the global
// history branch predictor.
// ----------------------------------------------------------------------------
package ghbp_pkg;

	typedef logic [1:0] ctr_t;

	localparam ctr_t CTR_SNT = 2'b00;
	localparam ctr_t CTR_WNT = 2'b01;
	localparam ctr_t CTR_WT  = 2'b10;
	localparam ctr_t CTR_ST  = 2'b11;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_idx_t REG_PC_BITS   = 2'd0;
	localparam cfg_idx_t REG_HIST_BITS = 2'd1;

	localparam cfg_data_t PC_BITS_RST   = 4'd10;
	localparam cfg_data_t HIST_BITS_RST = 4'd2;

	localparam int CNT_W = 32;
	typedef logic [CNT_W-1:0] cnt_t;

	// hysteresis: a weak counter jumps straight to a strong state
	function automatic ctr_t next_ctr(input ctr_t cur, input logic t);
		ctr_t nxt;
		case (cur) inside
			CTR_SNT:         nxt = t ? CTR_WNT : CTR_SNT;
			CTR_ST:          nxt = t ? CTR_ST : CTR_WT;
			CTR_WNT, CTR_WT: nxt = t ? CTR_ST : CTR_SNT;
			default:         nxt = CTR_SNT;
		endcase
		return nxt;
	endfunction

endpackage

// File: rtl/core/global_history_branch_predictor.sv
// ----------------------------------------------------------------------------
// global_history_branch_predictor
// Correlating predictor: global history above low pc bits indexes a table of
// 2-bit hysteresis counters, read-modify-written once per resolved branch.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) takes one resolved branch a word:
//   branch_pc and taken. output channel (out_valid/out_ready) returns one
//   word per branch: prediction, mispredict and the running mispredict_count.
//   cfg channel writes pc_bits (index 0) or hist_bits (index 1); other
//   indexes are dropped. cfg_ready is always high; write only while idle.
//   a word accepted on the input is read from the table into the read
//   stage, then moves into the output register once that is free.
//   throughput: one branch per cycle while the output is not stalled; the
//   table read happens at acceptance, the counter write-back as the branch
//   leaves the read stage; a read of the entry being written on the same
//   edge is served from a forwarding register. reset: history goes to all
//   ones, the miss total to zero, and a clearing pass sets every counter to
//   strongly taken, one entry a cycle; in_ready stays low meanwhile.
//   stall: the output register holds its word while out_ready is low; one
//   more branch can sit in the read stage, after which in_ready drops.
// ----------------------------------------------------------------------------
module global_history_branch_predictor #(
	parameter int INDEX_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [31:0]         branch_pc,
	input  logic                taken,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                prediction,
	output logic                mispredict,
	output ghbp_pkg::cnt_t      mispredict_count,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  ghbp_pkg::cfg_idx_t  cfg_index,
	input  ghbp_pkg::cfg_data_t cfg_data
);
	import ghbp_pkg::*;

	localparam int DEPTH = 1 << INDEX_BITS;
	localparam int SW    = $clog2(INDEX_BITS + 16);
	localparam int HW    = (INDEX_BITS > 1) ? $clog2(INDEX_BITS) : 1;

	localparam logic [SW-1:0]         IBITS    = SW'(INDEX_BITS);
	localparam logic [INDEX_BITS-1:0] IDX_LAST = {INDEX_BITS{1'b1}};
	localparam cnt_t                  CNT_MAX  = {CNT_W{1'b1}};

	ctr_t pht_mem [DEPTH];

	cfg_data_t pc_bits_q, hist_bits_q;
	logic [INDEX_BITS-1:0] history_q;
	cnt_t miss_total_q;
	logic clr_busy_q;
	logic [INDEX_BITS-1:0] clr_idx_q;

	logic s1_valid;
	logic [INDEX_BITS-1:0] idx_s1;
	logic taken_s1, fwd_s1;
	ctr_t fwd_ctr_s1, rd_s1;

	logic out_valid_q, prediction_q, mispredict_q;
	cnt_t mispredict_count_q;

	logic in_go, s1_go;
	logic [SW-1:0] m_eff, k_eff, room;
	logic [INDEX_BITS-1:0] idx_in;
	ctr_t cur_ctr, new_ctr;
	logic s1_pred, s1_miss;
	cnt_t miss_next;
	logic mem_we;
	logic [INDEX_BITS-1:0] mem_waddr;
	ctr_t mem_wdata;

	assign cfg_ready = 1'b1;
	assign s1_go     = s1_valid && (!out_valid_q || out_ready);
	assign in_ready  = !clr_busy_q && (!s1_valid || s1_go);
	assign in_go     = in_valid && in_ready;

	// cut the bit counts so that they fit the index
	always_comb begin
		m_eff = (SW'(pc_bits_q) > IBITS) ? IBITS : SW'(pc_bits_q);
		room  = IBITS - m_eff;
		k_eff = (SW'(hist_bits_q) > room) ? room : SW'(hist_bits_q);
	end

	// newest outcome lands on the top history bit of the index
	always_comb begin
		logic [SW-1:0] pos, j;
		for (int i = 0; i < INDEX_BITS; i++) begin
			pos = SW'(i);
			j   = m_eff + k_eff - SW'(1) - pos;
			if (pos < m_eff) begin
				idx_in[i] = branch_pc[i];
			end else if (pos < m_eff + k_eff) begin
				idx_in[i] = history_q[j[HW-1:0]];
			end else begin
				idx_in[i] = 1'b0;
			end
		end
	end

	assign cur_ctr   = fwd_s1 ? fwd_ctr_s1 : rd_s1;
	assign s1_pred   = cur_ctr[1];
	assign s1_miss   = s1_pred != taken_s1;
	assign new_ctr   = next_ctr(cur_ctr, taken_s1);
	assign miss_next = (s1_miss && miss_total_q != CNT_MAX) ? miss_total_q + cnt_t'(1)
		: miss_total_q;

	assign mem_we    = clr_busy_q || s1_go;
	assign mem_waddr = clr_busy_q ? clr_idx_q : idx_s1;
	assign mem_wdata = clr_busy_q ? CTR_ST : new_ctr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pht_mem[mem_waddr] <= mem_wdata;
		end
		if (in_go) begin
			rd_s1 <= pht_mem[idx_in];
		end
	end

	always_ff @(posedge clk) begin
		if (in_go) begin
			idx_s1     <= idx_in;
			taken_s1   <= taken;
			fwd_ctr_s1 <= new_ctr;
		end
		if (s1_go) begin
			prediction_q       <= s1_pred;
			mispredict_q       <= s1_miss;
			mispredict_count_q <= miss_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_bits_q    <= PC_BITS_RST;
			hist_bits_q  <= HIST_BITS_RST;
			history_q    <= '1;
			miss_total_q <= '0;
			clr_busy_q   <= 1'b1;
			clr_idx_q    <= '0;
			s1_valid     <= 1'b0;
			fwd_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_PC_BITS:   pc_bits_q <= cfg_data;
					REG_HIST_BITS: hist_bits_q <= cfg_data;
					default:       ;
				endcase
			end
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + INDEX_BITS'(1);
				if (clr_idx_q == IDX_LAST) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (in_go) begin
				history_q <= INDEX_BITS'({history_q, taken});
				// entry written on this same edge is not yet visible in the read
				fwd_s1 <= s1_go && (idx_s1 == idx_in);
			end
			if (s1_go) begin
				miss_total_q <= miss_next;
			end
			if (in_go) begin
				s1_valid <= 1'b1;
			end else if (s1_go) begin
				s1_valid <= 1'b0;
			end
			if (s1_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign prediction       = prediction_q;
	assign mispredict       = mispredict_q;
	assign mispredict_count = mispredict_count_q;

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !in_ready)
		else $error("branch accepted during table clear");

	a_stage_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !s1_go) |-> !in_ready)
		else $error("read stage overwritten while stalled");

	a_miss_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && miss_total_q != CNT_MAX) |=>
		(miss_total_q == $past(miss_total_q) + cnt_t'($past(s1_miss))))
		else $error("miss total stepped wrongly");

	a_out_matches_total: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go |=> (mispredict_count == miss_total_q))
		else $error("reported count differs from miss total");

endmodule
